// File: design/jcbe_pkg.sv
// Shared types and constants for the JTAG command byte engine.
package jcbe_pkg;

   // Widths of the host byte, the shift count and the sequencer step.
   localparam int ByteW  = 8;
   localparam int CountW = 6;
   localparam int StepW  = 4;

   // Bit positions inside a command byte.
   localparam int CmdLoadBit = 7;
   localparam int CmdReadBit = 6;
   localparam int CmdTdiBit  = 4;
   localparam int CmdTmsBit  = 1;
   localparam int CmdTckBit  = 0;

   // Final phase of a shifted byte: eight bits, two TCK phases each.
   localparam logic [StepW-1:0] StepLast = 4'd15;

   // Tag that marks a bit-bang read byte.
   localparam logic [ByteW-1:0] BitbangReadTag = 8'h02;

   // Depth of the command queue between front and back.
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   // Kind of work handed from the front to the back.
   typedef enum logic {
      CmdBitbang,
      CmdShift
   } cmd_kind_type;

   // One queued command.
   typedef struct packed {
      cmd_kind_type     kind;
      logic             tck;
      logic             tms;
      logic             tdi;
      logic             read_flag;
      logic [ByteW-1:0] host_byte;
      logic [ByteW-1:0] tdo_bits;
   } cmd_type;

   // Queue status seen by its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// File: design/jtag_command_byte_engine.sv
// Top level of the JTAG command byte engine: front end, command queue and back end.
//
// Host bytes enter on the req_ channel and pin updates leave on the rsp_ channel, each
// result giving the TCK, TMS and TDI levels after it plus an optional byte for the host.
// The front end takes one host byte per cycle while its four-entry command queue has
// room. A count-load command produces no result; a bit-bang command produces one
// result; a shifted data byte produces sixteen results, one per TCK phase. The back
// end emits at most one result per cycle, so bit-bang traffic sustains one byte per
// cycle while the pin side does not stall, and a shifted byte holds the back end until
// all sixteen of its results have been taken.
module jtag_command_byte_engine import jcbe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [ByteW-1:0] req_host_byte,
   input  logic [ByteW-1:0] req_tdo_bits,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_tck,
   output logic             rsp_tms,
   output logic             rsp_tdi,
   output logic             rsp_read_valid,
   output logic [ByteW-1:0] rsp_read_byte,
   output logic             rsp_last
);

   logic         push, pop;
   cmd_type      push_cmd, head_cmd;
   q_status_type q_status;

   // Classifies host bytes and keeps the mode state.
   jcbe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_host_byte (req_host_byte),
      .req_tdo_bits  (req_tdo_bits),
      .q_status      (q_status),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   // Decouples the two sides.
   jcbe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   // Sequences pin phases and delivers results.
   jcbe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (head_cmd),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tck        (rsp_tck),
      .rsp_tms        (rsp_tms),
      .rsp_tdi        (rsp_tdi),
      .rsp_read_valid (rsp_read_valid),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_last       (rsp_last)
   );

endmodule

// File: design/jcbe_front.sv
// Front end: accepts host bytes, tracks the mode and queues commands for the back end.
module jcbe_front import jcbe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [ByteW-1:0] req_host_byte,
   input  logic [ByteW-1:0] req_tdo_bits,
   input  q_status_type     q_status,
   output logic             push,
   output cmd_type          push_cmd
);

   logic [CountW-1:0] shift_count_ff, shift_count_in;
   logic              read_flag_ff, read_flag_in;
   logic              tms_ff, tms_in;
   logic              accept;
   logic              shift_mode;

   // An item is taken whenever the queue has room.
   assign req_stall  = q_status.full;
   assign accept     = req_valid && !q_status.full;
   assign shift_mode = (shift_count_ff != '0);

   // Classify the item and build the command for the back end.
   always_comb begin
      shift_count_in     = shift_count_ff;
      read_flag_in       = read_flag_ff;
      tms_in             = tms_ff;
      push               = 1'b0;
      push_cmd.kind      = CmdBitbang;
      push_cmd.tck       = req_host_byte[CmdTckBit];
      push_cmd.tms       = req_host_byte[CmdTmsBit];
      push_cmd.tdi       = req_host_byte[CmdTdiBit];
      push_cmd.read_flag = req_host_byte[CmdReadBit];
      push_cmd.host_byte = req_host_byte;
      push_cmd.tdo_bits  = req_tdo_bits;
      if (shift_mode) begin
         // Data byte: shift it out with the current TMS and read flag.
         push_cmd.kind      = CmdShift;
         push_cmd.tms       = tms_ff;
         push_cmd.read_flag = read_flag_ff;
         if (accept) begin
            push           = 1'b1;
            shift_count_in = shift_count_ff - 1'b1;
         end
      end else if (accept) begin
         read_flag_in = req_host_byte[CmdReadBit];
         if (req_host_byte[CmdLoadBit]) begin
            // Count load produces no result.
            shift_count_in = req_host_byte[CountW-1:0];
         end else begin
            push   = 1'b1;
            tms_in = req_host_byte[CmdTmsBit];
         end
      end
   end

   // Mode state.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_count_ff <= '0;
         read_flag_ff   <= 1'b0;
         tms_ff         <= 1'b0;
      end else begin
         shift_count_ff <= shift_count_in;
         read_flag_ff   <= read_flag_in;
         tms_ff         <= tms_in;
      end
   end

endmodule

// File: design/jcbe_queue.sv
// Short command queue between the front end and the back end.
module jcbe_queue import jcbe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head_cmd,
   output q_status_type q_status
);

   cmd_type          mem_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCntW-1:0] count_ff;

   assign q_status.full  = (count_ff == QCntW'(QDepth));
   assign q_status.empty = (count_ff == '0);
   assign head_cmd       = mem_ff[rd_ptr_ff];

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // The fill count never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCntW'(QDepth))
      else $error("command queue overfilled");

   // The front end never pushes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full command queue");

   // The back end never pops an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty command queue");

endmodule

// File: design/jcbe_back.sv
// Back end: steps through queued commands and drives the registered result channel.
module jcbe_back import jcbe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          head_cmd,
   input  q_status_type     q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_tck,
   output logic             rsp_tms,
   output logic             rsp_tdi,
   output logic             rsp_read_valid,
   output logic [ByteW-1:0] rsp_read_byte,
   output logic             rsp_last
);

   logic [StepW-1:0] step_ff;
   logic             rsp_valid_ff;
   logic             tck_ff, tms_ff, tdi_ff, read_valid_ff, last_ff;
   logic [ByteW-1:0] read_byte_ff;
   logic             out_free, fire, is_shift, final_step;
   logic             tck_in, tms_in, tdi_in, read_valid_in, last_in;
   logic [ByteW-1:0] read_byte_in;

   // A new result loads when the output register is empty or being taken.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = out_free && !q_status.empty;
   assign is_shift   = (head_cmd.kind == CmdShift);
   assign final_step = !is_shift || (step_ff == StepLast);
   assign pop        = fire && final_step;

   // Result for the current step of the head command.
   always_comb begin
      if (is_shift) begin
         // Even steps raise TCK, odd steps lower it; TDI goes LSB first.
         tck_in        = !step_ff[0];
         tms_in        = head_cmd.tms;
         tdi_in        = head_cmd.host_byte[step_ff[StepW-1:1]];
         last_in       = (step_ff == StepLast);
         read_valid_in = last_in && head_cmd.read_flag;
         read_byte_in  = read_valid_in ? head_cmd.tdo_bits : '0;
      end else begin
         tck_in        = head_cmd.tck;
         tms_in        = head_cmd.tms;
         tdi_in        = head_cmd.tdi;
         last_in       = 1'b1;
         read_valid_in = head_cmd.read_flag;
         read_byte_in  = head_cmd.read_flag
                       ? (BitbangReadTag | {{(ByteW-1){1'b0}}, head_cmd.tdo_bits[0]})
                       : '0;
      end
   end

   // Step counter and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            step_ff      <= final_step ? '0 : step_ff + 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (fire) begin
         tck_ff        <= tck_in;
         tms_ff        <= tms_in;
         tdi_ff        <= tdi_in;
         read_valid_ff <= read_valid_in;
         read_byte_ff  <= read_byte_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tck        = tck_ff;
   assign rsp_tms        = tms_ff;
   assign rsp_tdi        = tdi_ff;
   assign rsp_read_valid = read_valid_ff;
   assign rsp_read_byte  = read_byte_ff;
   assign rsp_last       = last_ff;

   // A byte in progress always has its shift command at the queue head.
   a_step_has_shift: assert property (@(posedge clock) disable iff (reset)
      (step_ff != '0) |-> (!q_status.empty && head_cmd.kind == CmdShift))
      else $error("shift sequence lost its command");

   // A read byte only travels on the final result of an item.
   a_read_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && read_valid_ff) |-> last_ff)
      else $error("read byte on a non-final result");

endmodule

// File: verif/jtag_command_byte_engine_tb.sv
// Self-checking testbench for the JTAG command byte engine: directed and random host bytes.
module jtag_command_byte_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import jcbe_pkg::*;

   localparam int IdlePercent = 8;
   localparam int CalmFirst   = 180;
   localparam int CalmLast    = 280;
   localparam int RandomItems = 420;
   localparam int DrainCycles = 64;
   localparam int QuietLimit  = 2000;

   // One host byte together with the TDO levels the pins will show while it is handled.
   typedef struct packed {
      logic [ByteW-1:0] host_byte;
      logic [ByteW-1:0] tdo_bits;
   } host_item_type;

   // Pin levels and read-back byte carried by one result item.
   typedef struct packed {
      logic             tck;
      logic             tms;
      logic             tdi;
      logic             read_valid;
      logic [ByteW-1:0] read_byte;
      logic             last;
   } pin_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [ByteW-1:0] req_host_byte = '0;
   logic [ByteW-1:0] req_tdo_bits = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_tck;
   logic             rsp_tms;
   logic             rsp_tdi;
   logic             rsp_read_valid;
   logic [ByteW-1:0] rsp_read_byte;
   logic             rsp_last;

   host_item_type  host_bytes_to_send[$];
   pin_result_type expected_pins[$];
   int             items_sent = 0;
   int             mismatches = 0;
   int             quiet_cycles = 0;
   logic           calm_window;

   // Our own copy of the engine state.
   logic [CountW-1:0] bytes_to_shift = '0;
   logic              read_flag = 1'b0;
   logic              tck_level = 1'b0;
   logic              tms_level = 1'b0;
   logic              tdi_level = 1'b0;

   jtag_command_byte_engine u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_host_byte  (req_host_byte),
      .req_tdo_bits   (req_tdo_bits),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tck        (rsp_tck),
      .rsp_tms        (rsp_tms),
      .rsp_tdi        (rsp_tdi),
      .rsp_read_valid (rsp_read_valid),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_last       (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Neither side idles while this window of items is being sent.
   assign calm_window = (items_sent >= CalmFirst) && (items_sent < CalmLast);

   // Record one expected result from the current pin levels.
   function automatic void push_pins(logic rd_valid, logic [ByteW-1:0] rd_byte, logic is_last);
      pin_result_type pins;
      pins.tck        = tck_level;
      pins.tms        = tms_level;
      pins.tdi        = tdi_level;
      pins.read_valid = rd_valid;
      pins.read_byte  = rd_byte;
      pins.last       = is_last;
      expected_pins.push_back(pins);
   endfunction

   // Work out the pin results that one accepted host byte causes.
   function automatic void apply_host_byte(host_item_type item);
      logic [ByteW-1:0] shifter;
      int               k;
      shifter = item.host_byte;
      if (bytes_to_shift != '0) begin
         // Data byte: LSB first, one TCK high and low phase per bit, TDO rotated in at the top.
         bytes_to_shift = bytes_to_shift - 1'b1;
         for (k = 0; k < ByteW; k++) begin
            tdi_level = shifter[0];
            shifter   = {item.tdo_bits[k], shifter[ByteW-1:1]};
            tck_level = 1'b1;
            push_pins(1'b0, '0, 1'b0);
            tck_level = 1'b0;
            if (k == ByteW - 1) begin
               push_pins(read_flag, read_flag ? shifter : '0, 1'b1);
            end else begin
               push_pins(1'b0, '0, 1'b0);
            end
         end
      end else begin
         read_flag = item.host_byte[CmdReadBit];
         if (item.host_byte[CmdLoadBit]) begin
            // Count load produces no result.
            bytes_to_shift = item.host_byte[CountW-1:0];
         end else begin
            tck_level = item.host_byte[CmdTckBit];
            tms_level = item.host_byte[CmdTmsBit];
            tdi_level = item.host_byte[CmdTdiBit];
            push_pins(read_flag,
                      read_flag ? (BitbangReadTag | {{(ByteW-1){1'b0}}, item.tdo_bits[0]})
                                : '0,
                      1'b1);
         end
      end
   endfunction

   function automatic void add_item(logic [ByteW-1:0] host_byte, logic [ByteW-1:0] tdo_bits);
      host_item_type item;
      item.host_byte = host_byte;
      item.tdo_bits  = tdo_bits;
      host_bytes_to_send.push_back(item);
   endfunction

   function automatic void check_field(string field, logic [ByteW-1:0] want,
                                       logic [ByteW-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   // Build the stimulus, release reset and wait for the engine to drain.
   initial begin : stimulus
      int               n;
      int               k;
      int               pick;
      int               random_count;
      logic [ByteW-1:0] cmd;

      // Bit-bang commands: all pins low, all pins high, ignored bits, reads with both TDO levels.
      add_item(8'h00, 8'h00);
      add_item(8'h13, 8'hFE);
      add_item(8'h40, 8'h01);
      add_item(8'h7F, 8'hFE);
      add_item(8'h2C, 8'hFF);
      add_item(8'h02, 8'h00);
      add_item(8'h50, 8'h00);
      // A zero count leaves the engine in bit-bang mode, with or without the read flag.
      add_item(8'h80, 8'hFF);
      add_item(8'h01, 8'h01);
      add_item(8'hC0, 8'h00);
      add_item(8'h41, 8'h01);
      // One data byte without read-back.
      add_item(8'h81, 8'h00);
      add_item(8'hA5, 8'h3C);
      // Two data bytes with read-back, all ones then all zeros.
      add_item(8'hC2, 8'h00);
      add_item(8'hFF, 8'h00);
      add_item(8'h00, 8'hFF);
      // Data bytes that look like commands are still shifted.
      add_item(8'hC1, 8'h00);
      add_item(8'h80, 8'hA5);
      add_item(8'hC1, 8'h00);
      add_item(8'h42, 8'h81);
      add_item(8'h53, 8'h00);

      // The largest count, followed by its data bytes.
      cmd = 8'h80;
      cmd[CmdReadBit] = 1'($urandom_range(1));
      cmd[CountW-1:0] = '1;
      add_item(cmd, 8'($urandom_range(255)));
      for (k = 0; k < (1 << CountW) - 1; k++) begin
         add_item(8'($urandom_range(255)), 8'($urandom_range(255)));
      end
      random_count = 1 << CountW;

      // Mostly well-formed shift sequences, with bit-bang commands and empty loads between.
      while (random_count < RandomItems) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            n = (pick < 3) ? $urandom_range((1 << CountW) - 1, 40) : $urandom_range(4, 1);
            cmd = 8'h80;
            cmd[CmdReadBit] = 1'($urandom_range(1));
            cmd[CountW-1:0] = CountW'(n);
            add_item(cmd, 8'($urandom_range(255)));
            for (k = 0; k < n; k++) begin
               add_item(8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            random_count += n + 1;
         end else if (pick < 90) begin
            cmd = 8'($urandom_range(255));
            cmd[CmdLoadBit] = 1'b0;
            add_item(cmd, 8'($urandom_range(255)));
            random_count++;
         end else begin
            cmd = 8'($urandom_range(255));
            cmd[CmdLoadBit] = 1'b1;
            cmd[CountW-1:0] = '0;
            add_item(cmd, 8'($urandom_range(255)));
            random_count++;
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (host_bytes_to_send.size() != 0 || req_valid);
      while (expected_pins.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatches == 0) begin
         $display("jtag_command_byte_engine_tb OK");
      end else begin
         $display("jtag_command_byte_engine_tb NOT OK");
      end
      $finish;
   end

   // Host side: offer the next item once the current one is taken, idling now and then.
   always @(posedge clock) begin : drive_host
      host_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (host_bytes_to_send.size() != 0 &&
             (calm_window || $urandom_range(99) >= IdlePercent)) begin
            item = host_bytes_to_send.pop_front();
            req_valid     <= 1'b1;
            req_host_byte <= item.host_byte;
            req_tdo_bits  <= item.tdo_bits;
            items_sent    <= items_sent + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Pin side: stall at random outside the calm window.
   always @(posedge clock) begin : drive_pin_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm_window && ($urandom_range(99) < IdlePercent);
      end
   end

   // Predict on every accepted host byte, then check every accepted result.
   always @(posedge clock) begin : watch_pins
      pin_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            apply_host_byte({req_host_byte, req_tdo_bits});
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pins.size() == 0) begin
               $display({"%0t: unexpected result: expected none, ",
                         "actual tck %b tms %b tdi %b rv %b byte 0x%0h last %b"},
                        $time, rsp_tck, rsp_tms, rsp_tdi, rsp_read_valid, rsp_read_byte,
                        rsp_last);
               mismatches++;
            end else begin
               want = expected_pins.pop_front();
               check_field("tck", ByteW'(want.tck), ByteW'(rsp_tck));
               check_field("tms", ByteW'(want.tms), ByteW'(rsp_tms));
               check_field("tdi", ByteW'(want.tdi), ByteW'(rsp_tdi));
               check_field("read_valid", ByteW'(want.read_valid), ByteW'(rsp_read_valid));
               check_field("read_byte", want.read_byte, rsp_read_byte);
               check_field("last", ByteW'(want.last), ByteW'(rsp_last));
            end
         end
      end
   end

   // End the run if neither channel moves an item for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no item moved for %0d cycles", $time, QuietLimit);
         $display("jtag_command_byte_engine_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
